[hdl/bnv_pkg.sv]
// bus name validator package: error codes, character classes, limits
// no dependencies

package bnv_pkg;

  localparam int MaxNameLength = 255;
  localparam int CountW        = 9;
  localparam int LimitW        = 17;

  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChDash  = 8'h2d;

  typedef enum logic [1:0] {
    CLS_START = 2'd0,
    CLS_DOT   = 2'd1,
    CLS_OTHER = 2'd2
  } cls_e;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_EMPTY        = 4'd1,
    ERR_UNIQUE_OFF   = 4'd2,
    ERR_WELLKNOWN_OFF = 4'd3,
    ERR_TOO_LONG     = 4'd4,
    ERR_DOUBLE_DOT   = 4'd5,
    ERR_LEADING_DOT  = 4'd6,
    ERR_DIGIT_AFTER_DOT = 4'd7,
    ERR_LEADING_DIGIT = 4'd8,
    ERR_BAD_CHAR     = 4'd9,
    ERR_TRAILING_DOT = 4'd10,
    ERR_NO_DOT       = 4'd11
  } err_e;

  localparam int CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ALLOW_UNIQUE     = 1'b0,
    REG_ALLOW_WELL_KNOWN = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic ok;
    err_e code;
    logic uniq;
  } verdict_t;

endpackage

[hdl/bnv_scan.sv]
// per-name scan state: length count, unique flag, class of last byte, dot-seen flag, first error
// classifies each stepped byte and forms the verdict; depends on bnv_pkg

module bnv_scan
  import bnv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       allow_unique_i,
  input  logic       allow_well_known_i,
  output verdict_t   verdict_o
);

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [LimitW-1:0] Limit    = LimitW'(MaxNameLength);

  logic [CountW-1:0] len_q, len_d;
  logic              uniq_q, uniq_d;
  cls_e              cls_q, cls_d;
  logic              dot_q, dot_d;
  err_e              ferr_q, ferr_d;
  err_e              cerr;
  logic              is_digit, is_alpha;
  err_e              code;

  always_comb begin
    is_digit = byte_i inside {[8'h30:8'h39]};
    is_alpha = (byte_i inside {[8'h41:8'h5a], [8'h61:8'h7a]}) ||
               byte_i == ChUnder || byte_i == ChDash;
    cerr  = ERR_NONE;
    cls_d = cls_q;
    dot_d = dot_q;
    if (byte_i == ChDot) begin
      dot_d = 1'b1;
      case (cls_q)
        CLS_DOT:   cerr = ERR_DOUBLE_DOT;
        CLS_START: cerr = ERR_LEADING_DOT;
        default:   cerr = ERR_NONE;
      endcase
      cls_d = CLS_DOT;
    end else if (is_digit) begin
      if (!uniq_q) begin
        case (cls_q)
          CLS_DOT:   cerr = ERR_DIGIT_AFTER_DOT;
          CLS_START: cerr = ERR_LEADING_DIGIT;
          default:   cerr = ERR_NONE;
        endcase
      end
      cls_d = CLS_OTHER;
    end else begin
      if (!is_alpha) cerr = ERR_BAD_CHAR;
      cls_d = CLS_OTHER;
    end
  end

  always_comb begin
    if (len_q == '0)                                code = ERR_EMPTY;
    else if (uniq_q && !allow_unique_i)             code = ERR_UNIQUE_OFF;
    else if (!uniq_q && !allow_well_known_i)        code = ERR_WELLKNOWN_OFF;
    else if (LimitW'(len_q) > Limit)                code = ERR_TOO_LONG;
    else if (ferr_q != ERR_NONE)                    code = ferr_q;
    else if (cls_q == CLS_DOT)                      code = ERR_TRAILING_DOT;
    else if (!dot_q)                                code = ERR_NO_DOT;
    else                                            code = ERR_NONE;
    verdict_o.ok   = (code == ERR_NONE);
    verdict_o.code = code;
    verdict_o.uniq = uniq_q;
  end

  always_comb begin
    len_d  = len_q;
    uniq_d = uniq_q;
    ferr_d = ferr_q;
    if (byte_i == 8'h00) begin
      len_d  = '0;
      uniq_d = 1'b0;
      ferr_d = ERR_NONE;
    end else begin
      if (len_q == '0 && byte_i == ChColon) begin
        uniq_d = 1'b1;
      end else if (ferr_q == ERR_NONE) begin
        ferr_d = cerr;
      end
      if (len_q != CountMax) len_d = len_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      uniq_q <= 1'b0;
      cls_q  <= CLS_START;
      dot_q  <= 1'b0;
      ferr_q <= ERR_NONE;
    end else if (step_i) begin
      len_q  <= len_d;
      uniq_q <= uniq_d;
      ferr_q <= ferr_d;
      if (byte_i == 8'h00) begin
        cls_q <= CLS_START;
        dot_q <= 1'b0;
      end else if (len_q == '0 && byte_i == ChColon) begin
        cls_q <= cls_q;
        dot_q <= dot_q;
      end else begin
        cls_q <= cls_d;
        dot_q <= dot_d;
      end
    end
  end

endmodule

[hdl/bus_name_validator.sv]
// Bus name validator: takes a bus name one byte per item, a zero byte ends
// the name and yields one result (verdict, error code, unique flag). Bytes
// are taken one per clock with no gaps, except that a terminator waits in the
// input register while an earlier result is still waiting to be taken; each
// byte is held in the input register and the scan state updates as it leaves,
// and a result is registered as its terminator leaves the input register.
// Configuration registers: index 0 allow_unique, index 1 allow_well_known,
// both reset to 1. Depends on bnv_pkg and bnv_scan.

module bus_name_validator
  import bnv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         name_byte_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic               cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_valid_o,
  output logic [3:0]         error_code_o,
  output logic               is_unique_name_o
);

  logic       in_vld_q;
  logic [7:0] byte_q;
  logic       adv;
  logic       term;
  logic       allow_uniq_q, allow_wk_q;
  logic       out_vld_q;
  verdict_t   verdict;
  verdict_t   res_q;

  assign term        = (byte_q == 8'h00);
  assign adv         = in_vld_q && (!term || !out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || adv;
  assign cfg_ready_o = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) byte_q <= name_byte_i;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_uniq_q <= 1'b1;
      allow_wk_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ALLOW_UNIQUE:     allow_uniq_q <= cfg_wdata_i;
        REG_ALLOW_WELL_KNOWN: allow_wk_q   <= cfg_wdata_i;
        default:              allow_uniq_q <= allow_uniq_q;
      endcase
    end
  end

  bnv_scan u_scan (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (adv),
    .byte_i             (byte_q),
    .allow_unique_i     (allow_uniq_q),
    .allow_well_known_i (allow_wk_q),
    .verdict_o          (verdict)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && term) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && term) res_q <= verdict;
  end

  assign out_valid_o      = out_vld_q;
  assign is_valid_o       = res_q.ok;
  assign error_code_o     = res_q.code;
  assign is_unique_name_o = res_q.uniq;

endmodule

[tb/testbench.sv]
// testbench for bus_name_validator: streams bus names byte by byte, predicts each verdict
// and checks every result field; depends on bnv_pkg and the bus_name_validator rtl
`timescale 1ns / 1ps

module testbench;
  import bnv_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int SegBytes   = 40;
  localparam logic [8:0] CountSat = 9'h1ff;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         name_byte_i = 8'h00;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = REG_ALLOW_UNIQUE;
  logic               cfg_wdata_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               is_valid_o;
  logic [3:0]         error_code_o;
  logic               is_unique_name_o;

  bus_name_validator u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .name_byte_i      (name_byte_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .is_valid_o       (is_valid_o),
    .error_code_o     (error_code_o),
    .is_unique_name_o (is_unique_name_o)
  );

  always #1 clk_i = ~clk_i;

  logic [7:0] byte_q[$];
  verdict_t   verdict_q[$];
  int         bytes_sent_n = 0;
  int         bytes_taken_n = 0;
  int         checked_n = 0;
  int         mismatch_n = 0;
  int         settings_n = 1;
  int         cycle_n = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       byte_taken = 1'b0;

  // configuration copy and scan state of the predictor
  logic       allow_unique_r = 1'b1;
  logic       allow_wk_r = 1'b1;
  logic [8:0] name_len = '0;
  logic       name_unique = 1'b0;
  cls_e       prev_cls = CLS_START;
  logic       dot_seen = 1'b0;
  err_e       first_err = ERR_NONE;

  task automatic report_mismatch(input string field, input logic [3:0] got,
                                 input logic [3:0] want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h", field, cycle_n, got, want);
    mismatch_n++;
  endtask

  task automatic predict_name_byte(input logic [7:0] b);
    err_e     e;
    verdict_t v;
    logic     letter;
    e = ERR_NONE;
    if (b != 8'h00) begin
      if (name_len == 0 && b == ChColon) begin
        name_unique = 1'b1;
      end else begin
        letter = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
        if (b == ChDot) begin
          dot_seen = 1'b1;
          if (prev_cls == CLS_DOT) e = ERR_DOUBLE_DOT;
          else if (prev_cls == CLS_START) e = ERR_LEADING_DOT;
          prev_cls = CLS_DOT;
        end else if (b >= 8'h30 && b <= 8'h39) begin
          if (!name_unique) begin
            if (prev_cls == CLS_DOT) e = ERR_DIGIT_AFTER_DOT;
            else if (prev_cls == CLS_START) e = ERR_LEADING_DIGIT;
          end
          prev_cls = CLS_OTHER;
        end else begin
          if (!(letter || b == ChUnder || b == ChDash)) e = ERR_BAD_CHAR;
          prev_cls = CLS_OTHER;
        end
        if (first_err == ERR_NONE) first_err = e;
      end
      if (name_len != CountSat) name_len = name_len + 9'd1;
    end else begin
      if (name_len == 0) v.code = ERR_EMPTY;
      else if (name_unique && !allow_unique_r) v.code = ERR_UNIQUE_OFF;
      else if (!name_unique && !allow_wk_r) v.code = ERR_WELLKNOWN_OFF;
      else if (int'(name_len) > MaxNameLength) v.code = ERR_TOO_LONG;
      else if (first_err != ERR_NONE) v.code = first_err;
      else if (prev_cls == CLS_DOT) v.code = ERR_TRAILING_DOT;
      else if (!dot_seen) v.code = ERR_NO_DOT;
      else v.code = ERR_NONE;
      v.ok = (v.code == ERR_NONE);
      v.uniq = name_unique;
      verdict_q.push_back(v);
      name_len = '0;
      name_unique = 1'b0;
      prev_cls = CLS_START;
      dot_seen = 1'b0;
      first_err = ERR_NONE;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result", error_code_o, 4'h0);
      end else begin
        exp_v = verdict_q.pop_front();
        if (is_valid_o !== exp_v.ok) report_mismatch("is_valid", 4'(is_valid_o), 4'(exp_v.ok));
        if (error_code_o !== exp_v.code) report_mismatch("error_code", error_code_o, exp_v.code);
        if (is_unique_name_o !== exp_v.uniq)
          report_mismatch("is_unique_name", 4'(is_unique_name_o), 4'(exp_v.uniq));
        checked_n++;
      end
    end
    byte_taken = rst_ni && in_valid_i && in_ready_o;
    if (byte_taken) begin
      predict_name_byte(name_byte_i);
      bytes_taken_n++;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!in_valid_i || byte_taken) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i  <= 1'b1;
        name_byte_i <= byte_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    byte_q.push_back(b);
    bytes_sent_n++;
  endtask

  task automatic send_name(input string s);
    foreach (s[i]) send_byte(s[i]);
    send_byte(8'h00);
  endtask

  function automatic logic [7:0] name_char(input logic no_digit);
    int pick;
    pick = $urandom_range(63);
    if (pick < 26) return 8'h61 + 8'(pick);
    if (pick < 52) return 8'h41 + 8'(pick - 26);
    if (pick < 62) begin
      if (no_digit && $urandom_range(7) != 0) return 8'h61 + 8'(pick - 52);
      return 8'h30 + 8'(pick - 52);
    end
    return (pick == 62) ? ChUnder : ChDash;
  endfunction

  task automatic send_random_name();
    logic [7:0] nm[$];
    int         pick;
    int         n_elem;
    int         elen;
    logic       uniq;
    pick = $urandom_range(99);
    if (pick < 3) begin
      // empty name
    end else if (pick < 15) begin
      repeat ($urandom_range(1, 8)) nm.push_back(8'($urandom_range(1, 255)));
    end else begin
      uniq = ($urandom_range(2) == 0);
      if (uniq) nm.push_back(ChColon);
      n_elem = $urandom_range(1, 4);
      for (int i = 0; i < n_elem; i++) begin
        if (i > 0) nm.push_back(ChDot);
        elen = $urandom_range(1, 6);
        for (int j = 0; j < elen; j++) nm.push_back(name_char(j == 0 && !uniq));
      end
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(4))
          0: nm[$urandom_range(nm.size() - 1)] = 8'($urandom_range(1, 255));
          1: nm.push_back(ChDot);
          2: nm.push_front(ChDot);
          3: nm.insert($urandom_range(nm.size()), ChDot);
          default: nm.insert($urandom_range(nm.size()), 8'h30 + 8'($urandom_range(9)));
        endcase
      end
    end
    foreach (nm[i]) send_byte(nm[i]);
    send_byte(8'h00);
  endtask

  task automatic send_long_name(input int len);
    send_byte(8'h61);
    send_byte(ChDot);
    repeat (len - 2) send_byte(8'h62);
    send_byte(8'h00);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_ALLOW_UNIQUE) allow_unique_r = val;
    else allow_wk_r = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (bytes_taken_n != bytes_sent_n) @(negedge clk_i);
    while (verdict_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    int start_n;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 87;
    // special cases at the reset configuration
    send_name("");
    send_name(":");
    send_name("A.z");
    send_name(":.9");
    send_name("a..");
    send_name("_.5");
    send_name("9a");
    send_byte(8'h61);
    send_byte(ChColon);
    send_byte(8'hff);
    send_byte(8'h00);
    send_name("x.");
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 87 : 0;
      recv_idle_pct = (mode == 0) ? 87 : (mode == 1) ? 20 : 0;
      for (int cfg = 0; cfg < 4; cfg++) begin
        if ($urandom_range(1)) begin
          write_reg(REG_ALLOW_WELL_KNOWN, !cfg[1]);
          write_reg(REG_ALLOW_UNIQUE, !cfg[0]);
        end else begin
          write_reg(REG_ALLOW_UNIQUE, !cfg[0]);
          write_reg(REG_ALLOW_WELL_KNOWN, !cfg[1]);
        end
        settings_n++;
        if (cfg == 0 && mode == 0) send_long_name(MaxNameLength);
        if (cfg == 0 && mode == 1) send_long_name(513);
        start_n = bytes_sent_n;
        while (bytes_sent_n - start_n < SegBytes) send_random_name();
        drain();
      end
    end

    $display("sent %0d name bytes, checked %0d verdicts over %0d register settings",
             bytes_sent_n, checked_n, settings_n);
    $display("idling patterns: sender-heavy, receiver-heavy and none");
    if (mismatch_n == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
